[hw/rtl/nud_pkg.sv]
// Shared types and constants for the non-restoring unsigned divider.
`default_nettype none
package nud_pkg;

    localparam int unsigned DATA_WIDTH_DEF = 96;
    localparam int unsigned LOW_W          = 64;
    localparam int unsigned HIGH_W         = 32;
    localparam int unsigned IN_TDATA_W     = 2 * (LOW_W + HIGH_W);
    localparam int unsigned OUT_TDATA_W    = 2 * (LOW_W + HIGH_W);

    // controls broadcast to every cell of the remainder row
    typedef struct packed {
        logic load;   // take a new divisor, clear partial remainder
        logic step;   // shift left by one and add/subtract
        logic sub;    // subtract the divisor (else add)
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_FIX  = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

endpackage
`default_nettype wire

[hw/rtl/nud_cell.sv]
// One bit slice of the partial remainder and divisor with its full adder.
`default_nettype none
module nud_cell (
    input  wire                 aclk,
    input  nud_pkg::cell_ctrl_t ctrl,
    input  wire                 d_load,
    input  wire                 p_in,
    input  wire                 c_in,
    output logic                p_out,
    output logic                sum_out,
    output logic                c_out
);
    import nud_pkg::*;

    logic p_reg;
    logic d_reg;
    logic s;
    logic b;

    assign s       = ctrl.step ? p_in : p_reg;
    assign b       = d_reg ^ ctrl.sub;
    assign sum_out = s ^ b ^ c_in;
    assign c_out   = (s & b) | (c_in & (s ^ b));
    assign p_out   = p_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            p_reg <= 1'b0;
            d_reg <= d_load;
        end else if (ctrl.step) begin
            p_reg <= sum_out;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/nonrestoring_unsigned_divider.sv]
// Top level of the non-restoring unsigned divider.
// Unsigned DATA_WIDTH-bit division, one quotient bit per cycle through a row of
// DATA_WIDTH+1 one-bit remainder cells sharing a ripple carry. An item runs one
// add/subtract step per quotient bit in ST_RUN, passes ST_FIX, and in ST_HOLD
// loads the result register with the corrected remainder; a stalled m_ side
// keeps it in ST_HOLD. A zero divisor skips the steps, sets m_tuser and gives
// zeros. One item is in flight at a time; a new item is accepted while the
// previous result still waits on the m_ side.
`default_nettype none
module nonrestoring_unsigned_divider #(
    parameter int unsigned DATA_WIDTH = nud_pkg::DATA_WIDTH_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // dividend_low, dividend_high, divisor_low, divisor_high
    input  wire  [nud_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // quotient_low, quotient_high, remainder_low, remainder_high
    output logic [nud_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // divide_by_zero
    output logic                             m_tuser
);
    import nud_pkg::*;

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned HW = DATA_WIDTH - LOW_W;
    localparam int unsigned CW = $clog2(DATA_WIDTH);

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [W-1:0]           a_reg, a_next;
    logic                   dz_reg, dz_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;

    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic         divisor_zero;
    logic         accept;
    logic         out_free;
    cell_ctrl_t   ctrl;
    logic [W:0]   p_vec;
    logic [W:0]   sum_vec;
    logic [W+1:0] carry;
    logic [W-1:0] rem;
    logic         sign;

    assign dividend     = {s_tdata[LOW_W +: HW], s_tdata[LOW_W-1:0]};
    assign divisor      = {s_tdata[LOW_W + HIGH_W + LOW_W +: HW],
                           s_tdata[LOW_W + HIGH_W +: LOW_W]};
    assign divisor_zero = (divisor == '0);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign sign     = p_vec[W];

    assign ctrl.load = accept;
    assign ctrl.step = (state_reg == ST_RUN);
    assign ctrl.sub  = (state_reg == ST_RUN) ? ~sign : 1'b0;
    assign carry[0]  = ctrl.sub;

    genvar i;
    generate
        for (i = 0; i <= W; i++) begin : g_cell
            logic p_in;
            logic d_ld;
            if (i == 0) begin : g_first
                assign p_in = a_reg[W-1];
            end else begin : g_rest
                assign p_in = p_vec[i-1];
            end
            if (i < W) begin : g_dbit
                assign d_ld = divisor[i];
            end else begin : g_dtop
                assign d_ld = 1'b0;
            end
            nud_cell u_cell (
                .aclk    (aclk),
                .ctrl    (ctrl),
                .d_load  (d_ld),
                .p_in    (p_in),
                .c_in    (carry[i]),
                .p_out   (p_vec[i]),
                .sum_out (sum_vec[i]),
                .c_out   (carry[i+1])
            );
        end
    endgenerate

    // negative remainder gets the divisor added back
    assign rem = sign ? sum_vec[W-1:0] : p_vec[W-1:0];

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        a_next        = a_reg;
        dz_next       = dz_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    a_next     = divisor_zero ? '0 : dividend;
                    dz_next    = divisor_zero;
                    cnt_next   = CW'(W - 1);
                    state_next = divisor_zero ? ST_FIX : ST_RUN;
                end
            end
            ST_RUN: begin
                a_next   = {a_reg[W-2:0], ~sum_vec[W]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {HIGH_W'(rem[W-1:LOW_W]), rem[LOW_W-1:0],
                                     HIGH_W'(a_reg[W-1:LOW_W]), a_reg[LOW_W-1:0]};
                    m_tuser_next  = dz_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cnt_reg     <= cnt_next;
        a_reg       <= a_next;
        dz_reg      <= dz_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

[hw/rtl/nud_checker.sv]
// Port-level assertions for the divider, bound to the top level.
`default_nettype none
module nud_assertions (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_tvalid,
    input wire                             s_tready,
    input wire [nud_pkg::IN_TDATA_W-1:0]   s_tdata,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [nud_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input wire                             m_tuser
);
    import nud_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("divide by zero result not zero");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared the cycle after an item");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind nonrestoring_unsigned_divider nud_assertions u_nud_assertions (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

[test/nud_checker.sv]
// Checker for the unsigned divider: watches both channels, predicts and compares.
`timescale 1ns / 100ps
`default_nettype none
module nud_checker (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    input  wire                             s_tready,
    input  wire [nud_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire                             m_tvalid,
    input  wire                             m_tready,
    input  wire [nud_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  wire                             m_tuser,
    output int                              errors,
    output int                              pending
);

    typedef struct {
        logic [95:0] quo;
        logic [95:0] rem;
        logic        dbz;
    } div_result_t;

    div_result_t quotients_due[$];

    function automatic div_result_t divide(logic [nud_pkg::IN_TDATA_W-1:0] d);
        div_result_t r;
        logic [95:0] num;
        logic [95:0] den;
        logic [96:0] part;
        num = d[95:0];
        den = d[191:96];
        r.quo = '0;
        r.rem = '0;
        r.dbz = 1'b0;
        if (den == '0) begin
            r.dbz = 1'b1;
        end else if (num != '0) begin
            part = '0;
            for (int i = 95; i >= 0; i--) begin
                part = {part[95:0], num[i]};
                if (part >= {1'b0, den}) begin
                    part = part - {1'b0, den};
                    r.quo[i] = 1'b1;
                end
            end
            r.rem = part[95:0];
        end
        return r;
    endfunction

    assign pending = quotients_due.size();

    initial errors = 0;

    always @(posedge aclk) begin
        div_result_t want;
        if (aresetn && s_tvalid && s_tready)
            quotients_due.push_back(divide(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (quotients_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result q=%h r=%h z=%b",
                             m_tdata[95:0], m_tdata[191:96], m_tuser);
            end else begin
                want = quotients_due.pop_front();
                if (want.quo !== m_tdata[95:0] || want.rem !== m_tdata[191:96]
                        || want.dbz !== m_tuser) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: want q=%h r=%h z=%b got q=%h r=%h z=%b",
                                 want.quo, want.rem, want.dbz,
                                 m_tdata[95:0], m_tdata[191:96], m_tuser);
                end
            end
        end
    end

endmodule
`default_nettype wire

[test/testbench.sv]
// Stimulus and verdict for the non-restoring unsigned divider.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    wire                             s_tready;
    logic [nud_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    wire                             m_tvalid;
    logic                            m_tready = 1'b0;
    wire  [nud_pkg::OUT_TDATA_W-1:0] m_tdata;
    wire                             m_tuser;
    int                              errors;
    int                              pending;

    nonrestoring_unsigned_divider dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    nud_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .errors(errors), .pending(pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver stall pattern: m_tready drawn at random each clock, mostly open, sometimes stalled
    always @(posedge aclk) begin
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 60)
            m_tready <= 1'b1;
        else if (mode < 90)
            m_tready <= 1'($urandom_range(0, 1));
        else
            m_tready <= 1'b0;
    end

    function automatic logic [95:0] rand96();
        logic [95:0] v;
        int sz;
        v = {$urandom, $urandom, $urandom};
        sz = $urandom_range(1, 96);
        v = v & ({96{1'b1}} >> (96 - sz));
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = 96'd1 << $urandom_range(0, 95);
            default: ;
        endcase
        return v;
    endfunction

    task automatic send(input logic [95:0] num, input logic [95:0] den);
        s_tdata  <= {den, num};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    initial begin
        logic [95:0] a;
        logic [95:0] b;
        int burst;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send('0, '0);
        send('1, '0);
        send('0, 96'd5);
        send('1, 96'd1);
        send('1, '1);
        send(96'd3, 96'd7);
        send('1, 96'd1 << 95);
        send(96'd1 << 95, 96'd3);
        send('1, 96'd2);
        send({32'hFFFF_FFFF, 64'd0}, 96'hFFFF_FFFF_FFFF_FFFF);
        send(96'd100, 96'd10);
        send('1 - 96'd1, '1);
        send(96'd1, 96'd1);
        gap();

        for (int n = 0; n < 1600; ) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && n < 1600; k++, n++) begin
                a = rand96();
                b = rand96();
                if ($urandom_range(0, 3) == 0)
                    b = b >> $urandom_range(0, 95);
                send(a, b);
            end
            if ($urandom_range(0, 2) == 0)
                gap();
            if (n % 400 < 20 && n > 0) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("[nonrestoring_unsigned_divider] OK");
        else
            $display("[nonrestoring_unsigned_divider] ERROR");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("[nonrestoring_unsigned_divider] ERROR");
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
hw/rtl/nud_pkg.sv
hw/rtl/nud_cell.sv
hw/rtl/nonrestoring_unsigned_divider.sv
hw/rtl/nud_checker.sv
test/nud_checker.sv
test/testbench.sv
